[rtl/core/frls_pkg.sv]
package frls_pkg;

	// Journal geometry
	localparam int SLOT_BYTES     = 256;
	localparam int SLOTS_PER_PAGE = 8;
	localparam int TOTAL_SLOTS    = 2 * SLOTS_PER_PAGE;
	localparam int CHECK_START    = SLOT_BYTES - 4;

	// Internal widths derived from the geometry
	localparam int OFS_W   = $clog2(SLOT_BYTES);
	localparam int SLOT_W  = $clog2(TOTAL_SLOTS + 1);
	localparam int TALLY_W = $clog2(TOTAL_SLOTS + 1);
	localparam int FF_W    = $clog2(SLOTS_PER_PAGE + 1);

	// Fixed field widths of the ports
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int FFO_W = 4;

	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [31:0] MAGIC_RESET = 32'h4B53_5735;
	localparam logic [7:0]  ERASED_BYTE = 8'hFF;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       scan_start;
	} frls_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] slot_index;
		logic             slot_free;
		logic             slot_valid;
		logic [31:0]      slot_sequence;
		logic             scan_done;
		logic             newest_found;
		logic [IDX_W-1:0] newest_slot;
		logic [31:0]      newest_sequence;
		logic [CNT_W-1:0] valid_count;
		logic [CNT_W-1:0] free_count;
		logic [FFO_W-1:0] first_free_a;
		logic [FFO_W-1:0] first_free_b;
	} frls_out_t;

	// Verdict of one slot, handed from the slot unit to the summary logic
	typedef struct packed {
		logic              emit;
		logic [SLOT_W-1:0] slot;
		logic              is_free;
		logic              valid;
		logic [31:0]       sequence_word;
		logic              done;
	} frls_verdict_t;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

[rtl/core/frls_slot_unit.sv]
module frls_slot_unit import frls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_value,
	input  logic          scan_start,
	input  logic [31:0]   record_magic,
	output frls_verdict_t verdict
);

	logic [OFS_W-1:0]  offset_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       crc_q, magic_q, seq_q, check_q;
	logic              erased_q;

	logic [OFS_W-1:0]  off_e;
	logic [SLOT_W-1:0] slot_e;
	logic [31:0]       crc_e, magic_e, seq_e, check_e;
	logic              erased_e;

	logic [31:0]       crc_n, magic_n, seq_n, check_n;
	logic              erased_n;
	logic [OFS_W-1:0]  chk_ofs;
	logic              active, last;

	// A start byte sees cleared state
	always_comb begin
		if (scan_start) begin
			off_e    = '0;
			slot_e   = '0;
			crc_e    = ALL_ONES;
			magic_e  = '0;
			seq_e    = '0;
			check_e  = '0;
			erased_e = 1'b1;
		end else begin
			off_e    = offset_q;
			slot_e   = slot_q;
			crc_e    = crc_q;
			magic_e  = magic_q;
			seq_e    = seq_q;
			check_e  = check_q;
			erased_e = erased_q;
		end
	end

	assign active  = slot_e < SLOT_W'(TOTAL_SLOTS);
	assign last    = off_e == OFS_W'(SLOT_BYTES - 1);
	assign chk_ofs = off_e - OFS_W'(CHECK_START);

	// Capture header and check word lanes; fold every byte before the check word into the CRC
	always_comb begin
		magic_n  = magic_e;
		seq_n    = seq_e;
		check_n  = check_e;
		crc_n    = crc_e;
		erased_n = erased_e && (byte_value == ERASED_BYTE);
		if (off_e < OFS_W'(4)) begin
			magic_n[{off_e[1:0], 3'b000} +: 8] = byte_value;
		end else if (off_e < OFS_W'(8)) begin
			seq_n[{off_e[1:0], 3'b000} +: 8] = byte_value;
		end
		if (off_e >= OFS_W'(CHECK_START)) begin
			check_n[{chk_ofs[1:0], 3'b000} +: 8] = byte_value;
		end else begin
			crc_n = crc32_byte(crc_e, byte_value);
		end
	end

	always_comb begin
		verdict.emit          = active && last;
		verdict.slot          = slot_e;
		verdict.is_free       = erased_n;
		verdict.valid         = (magic_n == record_magic) && ((crc_n ^ ALL_ONES) == check_n);
		verdict.sequence_word = seq_n;
		verdict.done          = slot_e == SLOT_W'(TOTAL_SLOTS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			slot_q   <= '0;
			crc_q    <= ALL_ONES;
			magic_q  <= '0;
			seq_q    <= '0;
			check_q  <= '0;
			erased_q <= 1'b1;
		end else if (step) begin
			if (!active) begin
				// past the last slot: drop the byte, keep whatever start cleared
				offset_q <= off_e;
				slot_q   <= slot_e;
				crc_q    <= crc_e;
				magic_q  <= magic_e;
				seq_q    <= seq_e;
				check_q  <= check_e;
				erased_q <= erased_e;
			end else if (last) begin
				offset_q <= '0;
				slot_q   <= slot_e + SLOT_W'(1);
				crc_q    <= ALL_ONES;
				magic_q  <= '0;
				seq_q    <= '0;
				check_q  <= '0;
				erased_q <= 1'b1;
			end else begin
				offset_q <= off_e + OFS_W'(1);
				slot_q   <= slot_e;
				crc_q    <= crc_n;
				magic_q  <= magic_n;
				seq_q    <= seq_n;
				check_q  <= check_n;
				erased_q <= erased_n;
			end
		end
	end

endmodule

[rtl/core/flash_record_log_scanner_core.sv]
// Journal scanner for a two-page append-only flash log.
// Source channel (src_valid / src_stall / src_data): one flash byte per word,
// in address order from page A slot 0; scan_start on a word clears all scan
// state and makes that byte the first of slot 0.
// Result channel (res_valid / res_stall / res_data): one word per finished
// slot, carrying the slot verdict and the running summary (newest record,
// valid and free counts, first free slot per page). scan_done marks the last
// slot; later bytes give nothing until the next scan_start.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the record magic;
// cfg_ready is always high. Write it only while the block is idle.
// Path: a slot's last byte is taken into the input register, and its verdict
// is then loaded into the result register. Throughput: one byte per cycle
// unless stalled as below; the byte-wide CRC step and the summary compare are
// both combinational.
// Stall: while a result waits under res_stall, bytes that finish no slot keep
// flowing; a byte that finishes a slot waits in the input register and
// src_stall rises until the result is taken.
// Reset: clears all scan state and restores the reset magic word.
module flash_record_log_scanner_core import frls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  frls_in_t    src_data,
	output logic        res_valid,
	input  logic        res_stall,
	output frls_out_t   res_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0]   magic_q;
	logic          valid_s1;
	frls_in_t      data_s1;
	frls_verdict_t verdict;
	logic          hold, step;

	// Summary state
	logic               found_q;
	logic [IDX_W-1:0]   best_slot_q;
	logic [31:0]        best_seq_q;
	logic [TALLY_W-1:0] valid_tally_q, free_tally_q;
	logic [FF_W-1:0]    first_a_q, first_b_q;

	logic               found_e, found_n;
	logic [IDX_W-1:0]   best_slot_e, best_slot_n;
	logic [31:0]        best_seq_e, best_seq_n, seq_diff;
	logic [TALLY_W-1:0] valid_tally_e, valid_tally_n, free_tally_e, free_tally_n;
	logic [FF_W-1:0]    first_a_e, first_a_n, first_b_e, first_b_n;
	logic [SLOT_W-1:0]  page_b_slot;
	logic               newer;

	// Configuration: take every write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			magic_q <= cfg_data;
		end
	end

	// Hold the input stage only when its byte finishes a slot and the result
	// register is still occupied by an untaken word.
	assign hold      = valid_s1 && verdict.emit && res_valid && res_stall;
	assign step      = valid_s1 && !hold;
	assign src_stall = hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			data_s1 <= src_data;
		end
	end

	frls_slot_unit u_slot (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.byte_value   (data_s1.byte_value),
		.scan_start   (data_s1.scan_start),
		.record_magic (magic_q),
		.verdict      (verdict)
	);

	// Summary as seen by this byte: cleared first on a start word
	always_comb begin
		if (data_s1.scan_start) begin
			found_e       = 1'b0;
			best_slot_e   = '0;
			best_seq_e    = '0;
			valid_tally_e = '0;
			free_tally_e  = '0;
			first_a_e     = FF_W'(SLOTS_PER_PAGE);
			first_b_e     = FF_W'(SLOTS_PER_PAGE);
		end else begin
			found_e       = found_q;
			best_slot_e   = best_slot_q;
			best_seq_e    = best_seq_q;
			valid_tally_e = valid_tally_q;
			free_tally_e  = free_tally_q;
			first_a_e     = first_a_q;
			first_b_e     = first_b_q;
		end
	end

	// Wrap-safe newer test: strictly positive signed difference, or no record kept yet
	assign seq_diff    = verdict.sequence_word - best_seq_e;
	assign newer       = !found_e || ((seq_diff != '0) && !seq_diff[31]);
	assign page_b_slot = verdict.slot - SLOT_W'(SLOTS_PER_PAGE);

	always_comb begin
		found_n       = found_e;
		best_slot_n   = best_slot_e;
		best_seq_n    = best_seq_e;
		valid_tally_n = valid_tally_e;
		free_tally_n  = free_tally_e;
		first_a_n     = first_a_e;
		first_b_n     = first_b_e;
		if (verdict.emit) begin
			if (verdict.is_free) begin
				// a free slot counts as free only, even if it also checks valid
				free_tally_n = free_tally_e + TALLY_W'(1);
				if (verdict.slot < SLOT_W'(SLOTS_PER_PAGE)) begin
					if (first_a_e == FF_W'(SLOTS_PER_PAGE)) begin
						first_a_n = FF_W'(verdict.slot);
					end
				end else if (first_b_e == FF_W'(SLOTS_PER_PAGE)) begin
					first_b_n = FF_W'(page_b_slot);
				end
			end else if (verdict.valid) begin
				valid_tally_n = valid_tally_e + TALLY_W'(1);
			end
			if (verdict.valid && newer) begin
				found_n     = 1'b1;
				best_slot_n = IDX_W'(verdict.slot);
				best_seq_n  = verdict.sequence_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q       <= 1'b0;
			best_slot_q   <= '0;
			best_seq_q    <= '0;
			valid_tally_q <= '0;
			free_tally_q  <= '0;
			first_a_q     <= FF_W'(SLOTS_PER_PAGE);
			first_b_q     <= FF_W'(SLOTS_PER_PAGE);
		end else if (step) begin
			found_q       <= found_n;
			best_slot_q   <= best_slot_n;
			best_seq_q    <= best_seq_n;
			valid_tally_q <= valid_tally_n;
			free_tally_q  <= free_tally_n;
			first_a_q     <= first_a_n;
			first_b_q     <= first_b_n;
		end
	end

	// Result register: load on a finished slot, drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (step && verdict.emit) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && verdict.emit) begin
			res_data.slot_index      <= IDX_W'(verdict.slot);
			res_data.slot_free       <= verdict.is_free;
			res_data.slot_valid      <= verdict.valid;
			res_data.slot_sequence   <= verdict.sequence_word;
			res_data.scan_done       <= verdict.done;
			res_data.newest_found    <= found_n;
			res_data.newest_slot     <= best_slot_n;
			res_data.newest_sequence <= best_seq_n;
			res_data.valid_count     <= CNT_W'(valid_tally_n);
			res_data.free_count      <= CNT_W'(free_tally_n);
			res_data.first_free_a    <= FFO_W'(first_a_n);
			res_data.first_free_b    <= FFO_W'(first_b_n);
		end
	end

	// A valid slot always leaves a newest record behind
	a_valid_sets_newest: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.slot_valid |-> res_data.newest_found)
		else $error("valid slot reported without a newest record");

	// With no newest record the kept slot and sequence stay cleared
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.newest_found |->
		(res_data.newest_sequence == '0) && (res_data.newest_slot == '0))
		else $error("newest fields set while no record found");

	// Counts never exceed the slots of one scan
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((CNT_W + 1)'(res_data.valid_count) + (CNT_W + 1)'(res_data.free_count))
		<= (CNT_W + 1)'(TOTAL_SLOTS))
		else $error("valid plus free count exceeds slot total");

	// The done flag comes only with the last slot
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.scan_done |-> res_data.slot_index == IDX_W'(TOTAL_SLOTS - 1))
		else $error("scan_done on a slot other than the last");

	// A held input stage only ever waits behind a stalled result
	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> res_valid && res_stall && valid_s1)
		else $error("input stalled without a waiting result");

endmodule
